/* sv/cvrb_pkg.sv */
// cvrb_pkg: shared types and constants for the 3x3 replicate-border convolution.
// No dependencies.
package cvrb_pkg;
  localparam int MaxWidth  = 2048;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int PixW      = 16;
  localparam int MaskW     = 8;
  localparam int EntryW    = PixW + MaskW;
  localparam int RowW      = 16;
  localparam int ColW      = 11;
  localparam int TapW      = 16;
  localparam int ResW      = 44;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 48;

  localparam logic [CfgIdxW-1:0] CfgWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTaps0  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTaps1  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTaps2  = 3'd4;

  localparam logic ActPixel = 1'b0;
  localparam logic ActFlush = 1'b1;

  typedef struct packed {
    logic [8:0][PixW-1:0] pix;
    logic [MaskW-1:0]     mask;
    logic [RowW-1:0]      row;
    logic [ColW-1:0]      col;
    logic                 fin;
  } job_t;
endpackage

/* sv/cvrb_queue.sv */
// cvrb_queue: two-entry queue of classified windows between front and back.
// Depends on cvrb_pkg.
module cvrb_queue
  import cvrb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output job_t rd_data_o,
  output logic empty_o
);
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o    = cnt_q == 2'd2;
  assign empty_o   = cnt_q == 2'd0;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wr_data_i;
  end
endmodule

/* sv/cvrb_front.sv */
// cvrb_front: accepts items, keeps line stores, window and counters, and
// emits the border-selected neighborhood of each result. Depends on cvrb_pkg.
module cvrb_front
  import cvrb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [11:0]      width_i,
  input  logic [15:0]      height_i,
  input  logic             push,
  output logic             full,
  input  logic             action_i,
  input  logic [PixW-1:0]  pixel_value_i,
  input  logic [MaskW-1:0] mask_weight_i,
  output logic             job_wr_o,
  output job_t             job_o,
  input  logic             job_full_i
);
  typedef enum logic {S_IDLE, S_UPD} state_e;
  state_e state_q;

  logic [EntryW-1:0] older_mem [MaxWidth];
  logic [EntryW-1:0] newer_mem [MaxWidth];
  logic [EntryW-1:0] up_rd_q, mid_rd_q;
  logic [EntryW-1:0] win_q [9];
  logic [EntryW-1:0] win_d [9];
  logic [EntryW-1:0] fresh_q, up_v, mid_v, fresh_v;
  logic [11:0]       in_col_q;
  logic [15:0]       in_row_q;
  logic [RowW-1:0]   res_row_q;
  logic [ColW-1:0]   res_col_q;
  logic              drain_q;
  logic [11:0]       w_eff;
  logic [15:0]       h_eff;
  logic              accept, emit, last_row, last_col, fin;
  logic [1:0]        rsel [3];
  logic [1:0]        csel [3];

  assign w_eff = (width_i < 12'd2) ? 12'd2 :
                 (width_i > 12'(MaxWidth)) ? 12'(MaxWidth) : width_i;
  assign h_eff = (height_i < 16'd2) ? 16'd2 : height_i;

  assign full   = (state_q != S_IDLE) || job_full_i;
  assign accept = push && !full && (action_i == drain_q);

  assign up_v    = in_col_q[11] ? '0 : up_rd_q;
  assign mid_v   = in_col_q[11] ? '0 : mid_rd_q;
  assign fresh_v = drain_q ? '0 : fresh_q;
  assign emit    = drain_q || (in_row_q >= 16'd2) || (in_row_q == 16'd1 && in_col_q >= 12'd1);

  assign last_row = ({1'b0, res_row_q} + 17'd1) >= {1'b0, h_eff};
  assign last_col = ({1'b0, res_col_q} + 12'd1) >= w_eff;
  assign fin      = last_row && last_col;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = up_v;
    win_d[5] = mid_v;
    win_d[8] = fresh_v;
    rsel[0] = (res_row_q == '0) ? 2'd1 : 2'd0;
    rsel[1] = 2'd1;
    rsel[2] = last_row ? 2'd1 : 2'd2;
    csel[0] = (res_col_q == '0) ? 2'd1 : 2'd0;
    csel[1] = 2'd1;
    csel[2] = last_col ? 2'd1 : 2'd2;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        job_o.pix[r*3+c] = win_d[rsel[r]*3 + csel[c]][PixW-1:0];
      end
    end
    job_o.mask = win_d[4][EntryW-1:PixW];
    job_o.row  = res_row_q;
    job_o.col  = res_col_q;
    job_o.fin  = fin;
  end

  assign job_wr_o = (state_q == S_UPD) && emit;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_rd_q  <= older_mem[in_col_q[AddrW-1:0]];
      mid_rd_q <= newer_mem[in_col_q[AddrW-1:0]];
      fresh_q  <= {mask_weight_i, pixel_value_i};
    end
    if (state_q == S_UPD && !drain_q && !in_col_q[11]) begin
      older_mem[in_col_q[AddrW-1:0]] <= mid_rd_q;
      newer_mem[in_col_q[AddrW-1:0]] <= fresh_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      in_col_q  <= '0;
      in_row_q  <= '0;
      res_row_q <= '0;
      res_col_q <= '0;
      drain_q   <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_UPD;
        end
        S_UPD: begin
          state_q <= S_IDLE;
          for (int i = 0; i < 9; i++) win_q[i] <= win_d[i];
          if (emit && fin) begin
            in_col_q  <= '0;
            in_row_q  <= '0;
            res_row_q <= '0;
            res_col_q <= '0;
            drain_q   <= 1'b0;
          end else begin
            if (!drain_q) begin
              if (in_col_q + 12'd1 >= w_eff) begin
                in_col_q <= '0;
                in_row_q <= in_row_q + 16'd1;
                if ({1'b0, in_row_q} + 17'd1 >= {1'b0, h_eff}) drain_q <= 1'b1;
              end else begin
                in_col_q <= in_col_q + 12'd1;
              end
            end else if (in_col_q != 12'hFFF) begin
              in_col_q <= in_col_q + 12'd1;
            end
            if (emit) begin
              if (last_col) begin
                res_col_q <= '0;
                res_row_q <= res_row_q + 16'd1;
              end else begin
                res_col_q <= res_col_q + 11'd1;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/cvrb_back.sv */
// cvrb_back: multiply-accumulate over the nine taps with one shared multiplier,
// mask scaling and the result register. Depends on cvrb_pkg.
module cvrb_back
  import cvrb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [9*TapW-1:0]     taps_i,
  input  job_t                  job_i,
  input  logic                  job_empty_i,
  output logic                  job_rd_o,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [ResW-1:0] filtered_value_o,
  output logic [RowW-1:0]       out_row_o,
  output logic [ColW-1:0]       out_column_o,
  output logic                  frame_last_o
);
  typedef enum logic [2:0] {B_IDLE, B_MUL, B_ACC, B_MASK, B_OUT} state_e;
  state_e state_q;

  job_t               job_q;
  logic [3:0]         k_q;
  logic signed [32:0] prod_q;
  logic signed [36:0] acc_q;
  logic signed [45:0] res_q;
  logic               out_v_q;
  logic [3:0]         tidx;
  logic signed [TapW-1:0] tap;

  assign tidx     = 4'd8 - k_q;
  assign tap      = taps_i[tidx*TapW +: TapW];
  assign job_rd_o = (state_q == B_IDLE) && !job_empty_i;
  assign empty    = !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      out_v_q <= 1'b0;
      k_q     <= '0;
    end else begin
      if (state_q == B_OUT && (!out_v_q || pop)) out_v_q <= 1'b1;
      else if (pop && out_v_q) out_v_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (!job_empty_i) begin
            job_q   <= job_i;
            k_q     <= '0;
            acc_q   <= '0;
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          prod_q  <= $signed({1'b0, job_q.pix[k_q]}) * tap;
          state_q <= B_ACC;
        end
        B_ACC: begin
          acc_q <= acc_q + 37'(prod_q);
          if (k_q == 4'd8) begin
            state_q <= B_MASK;
          end else begin
            k_q     <= k_q + 4'd1;
            state_q <= B_MUL;
          end
        end
        B_MASK: begin
          res_q   <= acc_q * $signed({1'b0, job_q.mask});
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (!out_v_q || pop) begin
            filtered_value_o <= res_q[ResW-1:0];
            out_row_o        <= job_q.row;
            out_column_o     <= job_q.col;
            frame_last_o     <= job_q.fin;
            state_q          <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end
endmodule

/* sv/conv3x3_replicate_border_masked_top.sv */
// conv3x3_replicate_border_masked_top: top level, configuration registers and
// front/queue/back wiring. Depends on cvrb_pkg, cvrb_front, cvrb_queue, cvrb_back.
//
// Streaming 3x3 convolution (flipped kernel, replicated border) scaled by each
// pixel's mask. The front reads the line stores for an item, then updates the
// window, taking no new item until then or while the queue is full; the back
// computes one result at a time on its shared tap multiplier (queue read, 9 taps
// as multiply then accumulate, mask scale, result load). Results lag by one row
// plus one pixel; after the last pixel, width+1 flush items drain the frame.
module conv3x3_replicate_border_masked_top
  import cvrb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  logic                   push,
  output logic                   full,
  input  logic                   action_i,
  input  logic [PixW-1:0]        pixel_value_i,
  input  logic [MaskW-1:0]       mask_weight_i,
  output logic                   empty,
  input  logic                   pop,
  output logic signed [ResW-1:0] filtered_value_o,
  output logic [RowW-1:0]        out_row_o,
  output logic [ColW-1:0]        out_column_o,
  output logic                   frame_last_o
);
  logic [11:0]         width_q;
  logic [15:0]         height_q;
  logic [CfgDataW-1:0] taps_q [3];
  job_t                wr_job, rd_job;
  logic                job_wr, job_rd, job_full, job_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 12'd2048;
      height_q  <= 16'd2048;
      taps_q[0] <= '0;
      taps_q[1] <= 48'd268435456;
      taps_q[2] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgWidth:  width_q   <= cfg_data_i[11:0];
        CfgHeight: height_q  <= cfg_data_i[15:0];
        CfgTaps0:  taps_q[0] <= cfg_data_i;
        CfgTaps1:  taps_q[1] <= cfg_data_i;
        CfgTaps2:  taps_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cvrb_front u_front (
    .clk_i, .rst_ni,
    .width_i(width_q), .height_i(height_q),
    .push, .full, .action_i, .pixel_value_i, .mask_weight_i,
    .job_wr_o(job_wr), .job_o(wr_job), .job_full_i(job_full)
  );

  cvrb_queue u_queue (
    .clk_i, .rst_ni,
    .wr_i(job_wr), .wr_data_i(wr_job), .full_o(job_full),
    .rd_i(job_rd), .rd_data_o(rd_job), .empty_o(job_empty)
  );

  cvrb_back u_back (
    .clk_i, .rst_ni,
    .taps_i({taps_q[2], taps_q[1], taps_q[0]}),
    .job_i(rd_job), .job_empty_i(job_empty), .job_rd_o(job_rd),
    .empty, .pop,
    .filtered_value_o, .out_row_o, .out_column_o, .frame_last_o
  );
endmodule
